// ----- hw/rtl/memory_to_memory_instruction_executor_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the executor checker.
// ----------------------------------------------------------------------------
`ifndef MEMORY_TO_MEMORY_INSTRUCTION_EXECUTOR_MACROS_SVH
`define MEMORY_TO_MEMORY_INSTRUCTION_EXECUTOR_MACROS_SVH

// implication checked every clock outside reset
`define M2M_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked every clock outside reset
`define M2M_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/m2m_pkg.sv -----
// ----------------------------------------------------------------------------
// m2m_pkg
// Types and constants shared by the instruction executor.
// ----------------------------------------------------------------------------
package m2m_pkg;

   localparam int MEM_DEPTH_DEFAULT = 4096;
   localparam int ADDR_W   = 24;
   localparam int DATA_W   = 64;
   localparam int STEP_W   = 31;
   localparam logic [ADDR_W-1:0] INSTR_BYTES = 24'd10;
   localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_EXEC  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2,
      KIND_START = 2'd3
   } kind_type;

   localparam logic [7:0] OP_HALT = 8'd0;
   localparam logic [7:0] OP_ADD  = 8'd1;
   localparam logic [7:0] OP_SUB  = 8'd2;
   localparam logic [7:0] OP_MUL  = 8'd3;
   localparam logic [7:0] OP_DIV  = 8'd4;
   localparam logic [7:0] OP_AND  = 8'd5;
   localparam logic [7:0] OP_OR   = 8'd6;
   localparam logic [7:0] OP_XOR  = 8'd7;
   localparam logic [7:0] OP_NOT  = 8'd8;
   localparam logic [7:0] OP_MOV  = 8'd9;
   localparam logic [7:0] OP_JUMP = 8'd10;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RDA, ST_RDB, ST_LATCH, ST_MUL, ST_DIV,
      ST_WRITE, ST_RESP
   } state_type;

   typedef struct packed {
      logic       start;
      logic [7:0] opcode;
   } alu_cmd_type;

   typedef struct packed {
      logic done;
   } alu_sts_type;

endpackage

// ----- hw/rtl/m2m_alu.sv -----
// ----------------------------------------------------------------------------
// m2m_alu
// Multicycle ALU: 16-bit partial-product multiply and restoring divide.
// ----------------------------------------------------------------------------
module m2m_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  m2m_pkg::alu_cmd_type cmd,
   input  logic [63:0]          opa,
   input  logic [63:0]          opb,
   output m2m_pkg::alu_sts_type sts,
   output logic [63:0]          result
);

   logic        busy_ff, busy_in;
   logic        div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic [64:0] rem_ff, rem_in;
   logic [64:0] trial;
   logic [15:0] mb;
   logic [79:0] pp;
   logic        last;

   assign mb    = b_ff[15:0];
   assign pp    = a_ff * mb;
   assign trial = {rem_ff[63:0], a_ff[63]} - {1'b0, b_ff};
   assign last  = div_ff ? (cnt_ff == 7'd63) : (cnt_ff == 7'd3);

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = (cmd.opcode == m2m_pkg::OP_DIV);
         cnt_in  = '0;
         a_in    = opa;
         b_in    = opb;
         acc_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 7'd1;
         if (last) busy_in = 1'b0;
         if (div_ff) begin
            a_in = {a_ff[62:0], 1'b0};
            if (!trial[64]) begin
               rem_in = trial;
               acc_in = {acc_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[63:0], a_ff[63]};
               acc_in = {acc_ff[62:0], 1'b0};
            end
         end else begin
            acc_in = acc_ff + pp[63:0];
            a_in   = {a_ff[47:0], 16'd0};
            b_in   = {16'd0, b_ff[63:16]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         div_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         div_ff  <= div_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign sts.done = busy_ff && last;
   assign result   = acc_in;

endmodule

// ----- hw/rtl/memory_to_memory_instruction_executor.sv -----
// Sequence: an accepted transaction steps through ST_RDA, ST_RDB, ST_LATCH,
// ST_WRITE and ST_RESP; multiply and divide pass ST_MUL and ST_DIV after ST_LATCH.
// Flow: one transaction at a time; the next is accepted after the response
// is taken with rsp_stall low. Divide is a 64-step restoring divide.
// Reset: synchronous; after reset a clearing pass zeroes every word of the
// data RAM, during which no request is accepted.
// ----------------------------------------------------------------------------
// memory_to_memory_instruction_executor
// Executes memory-to-memory instructions over a 64-bit data RAM.
// ----------------------------------------------------------------------------
module memory_to_memory_instruction_executor #(
   parameter int MEM_DEPTH = m2m_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_program_bytes,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [23:0] req_src_a_addr,
   input  logic [23:0] req_src_b_addr,
   input  logic [7:0]  req_opcode,
   input  logic [23:0] req_dest_addr,
   input  logic [23:0] req_mem_addr,
   input  logic [63:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [23:0] rsp_next_pc,
   output logic        rsp_running,
   output logic        rsp_halted,
   output logic [63:0] rsp_data_value,
   output logic [30:0] rsp_step_count
);

   localparam int AW = $clog2(MEM_DEPTH);
   localparam int SH = m2m_pkg::ADDR_W + AW;
   localparam logic [63:0] RECIP =
      ((64'd1 << SH) + 64'(MEM_DEPTH) - 64'd1) / 64'(MEM_DEPTH);
   localparam logic [23:0] DEPTH_A = 24'(MEM_DEPTH);

   m2m_pkg::state_type state_ff, state_in;
   logic [63:0] mem [MEM_DEPTH];
   logic [63:0] rdata_ff;
   logic        we;
   logic [AW-1:0] waddr, raddr;
   logic [63:0] wdata;
   logic [AW:0] clr_ff, clr_in;

   logic [23:0] pc_ff, pc_in;
   logic        halt_ff, halt_in;
   logic [30:0] steps_ff, steps_in;
   logic [23:0] pbytes_ff;

   logic [1:0]  kind_ff;
   logic [23:0] ra_ff, rb_ff, rd_ff, ma_ff;
   logic [7:0]  op_ff;
   logic [63:0] wv_ff;
   logic [63:0] a_ff, a_in, b_ff, b_in, res_ff, res_in;
   logic        ovalid_ff, ovalid_in;

   m2m_pkg::alu_cmd_type cmd;
   m2m_pkg::alu_sts_type sts;
   logic [63:0] alu_res;
   logic        run_now;
   logic [24:0] pc_sum;

   function automatic logic [AW-1:0] phys(input logic [23:0] a);
      logic [48:0] prod;
      logic [23:0] quo;
      logic [23:0] rem;
      prod = 49'(a) * 49'(RECIP[24:0]);
      quo  = 24'(prod >> SH);
      rem  = a - quo * DEPTH_A;
      return rem[AW-1:0];
   endfunction

   assign pc_sum    = {1'b0, pc_ff} + {1'b0, m2m_pkg::INSTR_BYTES};
   assign run_now   = !halt_ff && (pc_sum <= {1'b0, pbytes_ff});
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != m2m_pkg::ST_IDLE) || ovalid_ff;

   m2m_alu u_alu (
      .clock, .reset, .cmd, .opa(a_ff), .opb(b_ff), .sts, .result(alu_res)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         m2m_pkg::ST_CLEAR:
            if (clr_ff == (AW+1)'(MEM_DEPTH - 1)) state_in = m2m_pkg::ST_IDLE;
         m2m_pkg::ST_IDLE:
            if (req_valid && !req_stall) state_in = m2m_pkg::ST_RDA;
         m2m_pkg::ST_RDA: state_in = m2m_pkg::ST_RDB;
         m2m_pkg::ST_RDB: state_in = m2m_pkg::ST_LATCH;
         m2m_pkg::ST_LATCH:
            if (kind_ff == m2m_pkg::KIND_EXEC && run_now &&
                (op_ff == m2m_pkg::OP_MUL || op_ff == m2m_pkg::OP_DIV))
               state_in = m2m_pkg::ST_MUL;
            else
               state_in = m2m_pkg::ST_WRITE;
         m2m_pkg::ST_MUL: state_in = m2m_pkg::ST_DIV;
         m2m_pkg::ST_DIV: if (sts.done) state_in = m2m_pkg::ST_WRITE;
         m2m_pkg::ST_WRITE: state_in = m2m_pkg::ST_RESP;
         m2m_pkg::ST_RESP: state_in = m2m_pkg::ST_IDLE;
         default: state_in = m2m_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      clr_in    = clr_ff;
      we        = 1'b0;
      waddr     = phys(rd_ff);
      wdata     = res_ff;
      raddr     = phys(ra_ff);
      a_in      = a_ff;
      b_in      = b_ff;
      res_in    = res_ff;
      pc_in     = pc_ff;
      halt_in   = halt_ff;
      steps_in  = steps_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      cmd.start  = (state_ff == m2m_pkg::ST_MUL);
      cmd.opcode = op_ff;
      case (state_ff)
         m2m_pkg::ST_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff[AW-1:0];
            wdata  = '0;
            clr_in = clr_ff + (AW+1)'(1);
         end
         m2m_pkg::ST_RDA: raddr = phys(kind_ff == m2m_pkg::KIND_READ ? ma_ff : ra_ff);
         m2m_pkg::ST_RDB: begin
            raddr = phys(rb_ff);
            a_in  = rdata_ff;
         end
         m2m_pkg::ST_LATCH: begin
            b_in = rdata_ff;
            case (kind_ff)
               m2m_pkg::KIND_EXEC: begin
                  res_in = '0;
                  if (run_now) begin
                     case (op_ff)
                        m2m_pkg::OP_ADD: res_in = a_ff + rdata_ff;
                        m2m_pkg::OP_SUB: res_in = a_ff - rdata_ff;
                        m2m_pkg::OP_AND: res_in = a_ff & rdata_ff;
                        m2m_pkg::OP_OR:  res_in = a_ff | rdata_ff;
                        m2m_pkg::OP_XOR: res_in = a_ff ^ rdata_ff;
                        m2m_pkg::OP_NOT: res_in = ~a_ff;
                        m2m_pkg::OP_MOV: res_in = a_ff;
                        default:         res_in = '0;
                     endcase
                  end
               end
               m2m_pkg::KIND_WRITE: res_in = wv_ff;
               m2m_pkg::KIND_READ:  res_in = a_ff;
               default:             res_in = '0;
            endcase
         end
         m2m_pkg::ST_DIV:
            if (sts.done) res_in = (op_ff == m2m_pkg::OP_DIV && b_ff == '0) ? '0 : alu_res;
         m2m_pkg::ST_WRITE: begin
            case (kind_ff)
               m2m_pkg::KIND_EXEC:
                  if (run_now) begin
                     if (steps_ff != m2m_pkg::STEP_MAX) steps_in = steps_ff + 31'd1;
                     if (op_ff == m2m_pkg::OP_HALT) begin
                        halt_in = 1'b1;
                     end else if (op_ff == m2m_pkg::OP_JUMP) begin
                        pc_in = ra_ff;
                     end else begin
                        we    = 1'b1;
                        pc_in = pc_sum[23:0];
                     end
                  end
               m2m_pkg::KIND_WRITE: begin
                  we    = 1'b1;
                  waddr = phys(ma_ff);
               end
               m2m_pkg::KIND_START: begin
                  pc_in    = '0;
                  halt_in  = 1'b0;
                  steps_in = '0;
               end
               default: ;
            endcase
         end
         m2m_pkg::ST_RESP: ovalid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= m2m_pkg::ST_CLEAR;
         clr_ff    <= '0;
         pc_ff     <= '0;
         halt_ff   <= 1'b0;
         steps_ff  <= '0;
         pbytes_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         pc_ff     <= pc_in;
         halt_ff   <= halt_in;
         steps_ff  <= steps_in;
         ovalid_ff <= ovalid_in;
         if (csr_valid) pbytes_ff <= csr_program_bytes;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      res_ff <= res_in;
      if (req_valid && !req_stall) begin
         kind_ff <= req_kind;
         ra_ff   <= req_src_a_addr;
         rb_ff   <= req_src_b_addr;
         op_ff   <= req_opcode;
         rd_ff   <= req_dest_addr;
         ma_ff   <= req_mem_addr;
         wv_ff   <= req_write_value;
      end
   end

   assign rsp_valid      = ovalid_ff;
   assign rsp_next_pc    = pc_ff;
   assign rsp_running    = run_now;
   assign rsp_halted     = halt_ff;
   assign rsp_data_value = res_ff;
   assign rsp_step_count = steps_ff;

endmodule

// ----- hw/rtl/m2m_checker.sv -----
// ----------------------------------------------------------------------------
// m2m_checker
// Port-level checks of the executor, bound to the top level.
// ----------------------------------------------------------------------------
`include "memory_to_memory_instruction_executor_macros.svh"

module m2m_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_running,
   input logic        rsp_halted
);

   `M2M_ASSERT_IMPL(a_one_at_a_time, clock, reset, rsp_valid, req_stall)
   `M2M_ASSERT_IMPL(a_halt_stops, clock, reset, rsp_valid && rsp_halted, !rsp_running)
   `M2M_ASSERT_NEXT(a_accept_stalls, clock, reset, req_valid && !req_stall, req_stall)
   `M2M_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind memory_to_memory_instruction_executor m2m_checker u_m2m_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_running, .rsp_halted
);
